// ----- hdl/nearest_palette_color_search_macros.svh -----
// ---------------------------------------------------------------------------
// nearest palette colour search: assertion macros
// clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// condition holds at every edge
`define NPC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent at the same edge
`define NPC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/npc_pkg.sv -----
// ---------------------------------------------------------------------------
// npc_pkg
// shared constants, types and the channel distance function for the
// nearest palette colour search
// ---------------------------------------------------------------------------
package npc_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W           = 8;
	localparam int COLOR_W         = 32;
	localparam int CH_W            = 8;
	localparam int NUM_CH          = 4;
	localparam int SQ_W            = 2 * CH_W;
	// four squares of at most 255*255 fit in 18 bits
	localparam int DIST_W          = SQ_W + 2;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [CH_W-1:0]    chan_t;
	typedef logic [SQ_W-1:0]    sq_t;
	typedef logic [DIST_W-1:0]  dist_t;

	// above any real distance, so the first entry always wins
	localparam dist_t DIST_INIT = '1;

	typedef struct packed {
		logic   vld;
		logic   cmd;
		idx_t   idx;
		color_t color;
		dist_t  best_dist;
		idx_t   best_idx;
	} flow_t;

	function automatic sq_t sq_diff(input chan_t a, input chan_t b);
		chan_t d;
		d = (a > b) ? (a - b) : (b - a);
		return sq_t'(d) * sq_t'(d);
	endfunction

endpackage

// ----- hdl/npc_cell.sv -----
// ---------------------------------------------------------------------------
// npc_cell
// one palette entry of the search row: takes the word from its upstream
// neighbour, loads its entry on a matching write, and on a lookup keeps the
// nearer of the incoming best and its own entry; two register stages
// ---------------------------------------------------------------------------
module npc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  npc_pkg::idx_t  cell_idx,
	input  npc_pkg::flow_t up,
	output npc_pkg::flow_t dn
);

	npc_pkg::color_t entry_q;
	npc_pkg::flow_t  up_s1;
	npc_pkg::sq_t    sq_s1 [npc_pkg::NUM_CH];
	npc_pkg::flow_t  dn_s2;
	npc_pkg::flow_t  dn_next;
	npc_pkg::dist_t  dist_sum;
	logic            closer;

	// palette entry, loaded as the write word passes this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift_en && up.vld && up.cmd == npc_pkg::CMD_WRITE
				&& up.idx == cell_idx) begin
			entry_q <= up.color;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int k = 0; k < npc_pkg::NUM_CH; k++) begin
				sq_s1[k] <= npc_pkg::sq_diff(up.color[k*npc_pkg::CH_W +: npc_pkg::CH_W],
					entry_q[k*npc_pkg::CH_W +: npc_pkg::CH_W]);
			end
		end
	end

	assign dist_sum = npc_pkg::dist_t'(sq_s1[0]) + npc_pkg::dist_t'(sq_s1[1])
		+ npc_pkg::dist_t'(sq_s1[2]) + npc_pkg::dist_t'(sq_s1[3]);

	// strict less-than keeps the lower index on a tie
	assign closer = up_s1.vld && up_s1.cmd == npc_pkg::CMD_LOOKUP
		&& dist_sum < up_s1.best_dist;

	always_comb begin
		dn_next = up_s1;
		if (closer) begin
			dn_next.best_dist = dist_sum;
			dn_next.best_idx  = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_s1 <= '0;
			dn_s2 <= '0;
		end else if (shift_en) begin
			up_s1 <= up;
			dn_s2 <= dn_next;
		end
	end

	assign dn = dn_s2;

endmodule

// ----- hdl/nearest_palette_color_search.sv -----
// ---------------------------------------------------------------------------
// nearest_palette_color_search
// palette of rgba colours in a row of cells; a lookup word walks the row and
// leaves with the index of the nearest entry, lowest index on ties
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  req     | req_valid, req_ready | cmd, entry_index, rgba_color
//  rsp     | rsp_valid, rsp_ready | best_index
//
//  one word accepted per cycle while the row advances; a lookup result passes
//  the two register stages of every cell and then the response register
//  writes travel the same row, so every lookup sees the palette as of its turn
//  reset clears every entry to zero at once; no clearing pass
//  the whole row advances only while the response register is free or taken
// ---------------------------------------------------------------------------
module nearest_palette_color_search (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic                    cmd,
	input  npc_pkg::idx_t           entry_index,
	input  npc_pkg::color_t         rgba_color,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output npc_pkg::idx_t           best_index
);

	npc_pkg::flow_t link [npc_pkg::PALETTE_ENTRIES+1];
	logic           shift_en;
	logic           rsp_valid_q;
	npc_pkg::idx_t  best_index_q;

	assign shift_en  = !rsp_valid_q || rsp_ready;
	assign req_ready = shift_en;

	always_comb begin
		link[0].vld       = req_valid;
		link[0].cmd       = cmd;
		link[0].idx       = entry_index;
		link[0].color     = rgba_color;
		link[0].best_dist = npc_pkg::DIST_INIT;
		link[0].best_idx  = '0;
	end

	for (genvar g = 0; g < npc_pkg::PALETTE_ENTRIES; g++) begin : g_cell
		npc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.cell_idx (npc_pkg::idx_t'(g)),
			.up       (link[g]),
			.dn       (link[g+1])
		);
	end

	// response word register, writes drop out here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (shift_en) begin
			rsp_valid_q <= link[npc_pkg::PALETTE_ENTRIES].vld
				&& link[npc_pkg::PALETTE_ENTRIES].cmd == npc_pkg::CMD_LOOKUP;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			best_index_q <= link[npc_pkg::PALETTE_ENTRIES].best_idx;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign best_index = best_index_q;

`include "nearest_palette_color_search_macros.svh"

	`NPC_ASSERT_NEXT(a_write_no_rsp,
		shift_en && link[npc_pkg::PALETTE_ENTRIES].vld
			&& link[npc_pkg::PALETTE_ENTRIES].cmd == npc_pkg::CMD_WRITE,
		!rsp_valid, "write word produced a response")
	`NPC_ASSERT_SAME(a_lookup_found,
		link[npc_pkg::PALETTE_ENTRIES].vld
			&& link[npc_pkg::PALETTE_ENTRIES].cmd == npc_pkg::CMD_LOOKUP,
		link[npc_pkg::PALETTE_ENTRIES].best_dist != npc_pkg::DIST_INIT,
		"lookup left the row without a nearest entry")
	`NPC_ASSERT_ALWAYS(a_index_in_range,
		!rsp_valid || ({1'b0, best_index} < (npc_pkg::IDX_W+1)'(npc_pkg::PALETTE_ENTRIES)),
		"best index beyond the palette")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: nearest palette colour search
// Drives palette writes and pixel lookups into the block. Each accepted
// lookup is predicted against a local copy of the palette. Responses are
// checked in order against the predicted nearest index. Both channels idle
// and stall at random, apart from one stretch that runs at full rate.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int  HALF_PERIOD = 5;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  DRAIN_CYCLES = 2 * npc_pkg::PALETTE_ENTRIES + 100;
	localparam int  RANDOM_ITEMS = 1800;

	typedef struct {
		logic            op;
		npc_pkg::idx_t   idx;
		npc_pkg::color_t color;
	} req_word_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_ready;
	logic            cmd = npc_pkg::CMD_WRITE;
	npc_pkg::idx_t   entry_index = '0;
	npc_pkg::color_t rgba_color = '0;
	logic            rsp_valid;
	logic            rsp_ready = 1'b0;
	npc_pkg::idx_t   best_index;

	req_word_t       pending_words[$];
	npc_pkg::idx_t   expected_index[$];
	npc_pkg::color_t palette_model[npc_pkg::PALETTE_ENTRIES];
	npc_pkg::color_t stim_palette[npc_pkg::PALETTE_ENTRIES];

	int cycle_count = 0;
	int error_count = 0;
	int writes_done = 0;
	int lookups_done = 0;
	int results_checked = 0;

	nearest_palette_color_search dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.cmd         (cmd),
		.entry_index (entry_index),
		.rgba_color  (rgba_color),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.best_index  (best_index)
	);

	always #HALF_PERIOD clk = ~clk;

	// full-rate window: no idling on either side
	function automatic logic take_break();
		if (cycle_count >= 1000 && cycle_count < 1800)
			return 1'b0;
		return ($urandom_range(0, 99) < 23);
	endfunction

	function automatic int unsigned colour_dist(input npc_pkg::color_t a,
			input npc_pkg::color_t b);
		int unsigned sum;
		int da;
		int db;
		sum = 0;
		for (int c = 0; c < 4; c++) begin
			da = a[8*c +: 8];
			db = b[8*c +: 8];
			sum += (da - db) * (da - db);
		end
		return sum;
	endfunction

	function automatic npc_pkg::idx_t nearest_entry(input npc_pkg::color_t pixel);
		int unsigned best_d;
		int unsigned d;
		npc_pkg::idx_t best;
		best = '0;
		best_d = colour_dist(pixel, palette_model[0]);
		for (int i = 1; i < npc_pkg::PALETTE_ENTRIES; i++) begin
			d = colour_dist(pixel, palette_model[i]);
			// strict compare keeps the lowest index on a tie
			if (d < best_d) begin
				best_d = d;
				best = npc_pkg::idx_t'(i);
			end
		end
		return best;
	endfunction

	task automatic queue_word(input logic op, input npc_pkg::idx_t idx,
			input npc_pkg::color_t color);
		req_word_t w;
		w.op = op;
		w.idx = idx;
		w.color = color;
		pending_words = {pending_words, w};
		if (op == npc_pkg::CMD_WRITE && int'(idx) < npc_pkg::PALETTE_ENTRIES)
			stim_palette[idx] = color;
	endtask

	function automatic npc_pkg::idx_t rand_idx();
		return npc_pkg::idx_t'($urandom_range(0, 255));
	endfunction

	// a pixel a few steps away from a palette colour, clamped per channel
	function automatic npc_pkg::color_t nudge(input npc_pkg::color_t base);
		npc_pkg::color_t res;
		int ch;
		for (int c = 0; c < 4; c++) begin
			ch = int'(base[8*c +: 8]) + int'($urandom_range(0, 6)) - 3;
			if (ch < 0)
				ch = 0;
			if (ch > 255)
				ch = 255;
			res[8*c +: 8] = ch[7:0];
		end
		return res;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, expected_index.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// driver: predict on acceptance, then offer the next word
	always @(posedge clk or negedge arst_n) begin : driver
		req_word_t w;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				if (cmd == npc_pkg::CMD_WRITE) begin
					writes_done++;
					if (int'(entry_index) < npc_pkg::PALETTE_ENTRIES)
						palette_model[entry_index] = rgba_color;
				end else begin
					lookups_done++;
					expected_index = {expected_index, nearest_entry(rgba_color)};
				end
			end
			if (!req_valid || req_ready) begin
				if (pending_words.size() != 0 && !take_break()) begin
					w = pending_words.pop_front();
					req_valid <= 1'b1;
					cmd <= w.op;
					entry_index <= w.idx;
					rgba_color <= w.color;
				end else begin
					// noise on the payload while nothing is offered
					req_valid <= 1'b0;
					cmd <= 1'($urandom_range(0, 1));
					entry_index <= rand_idx();
					rgba_color <= $urandom;
				end
			end
		end
	end

	// monitor: check each response word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor
		npc_pkg::idx_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_index.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected response: best_index %0d", best_index);
				end else begin
					want = expected_index.pop_front();
					results_checked++;
					if (best_index !== want) begin
						error_count++;
						if (error_count <= 10)
							$display("mismatch on response %0d: expected %0d, got %0d",
								results_checked, want, best_index);
					end
				end
			end
			rsp_ready <= !take_break();
		end
	end

	initial begin : stimulus
		int r;
		int k;
		npc_pkg::color_t pix;
		for (int i = 0; i < npc_pkg::PALETTE_ENTRIES; i++) begin
			palette_model[i] = '0;
			stim_palette[i] = '0;
		end

		// cleared palette: every entry ties, index 0 wins; then entry 255 turns white
		queue_word(npc_pkg::CMD_LOOKUP, 8'hff, 32'h0000_0000);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h00, 32'hffff_ffff);
		queue_word(npc_pkg::CMD_WRITE, 8'hff, 32'hffff_ffff);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h5a, 32'hffff_ffff);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h00, 32'h8080_8080);
		queue_word(npc_pkg::CMD_LOOKUP, 8'hff, 32'h7f7f_7f7f);
		// duplicate colours: the first copy answers
		queue_word(npc_pkg::CMD_WRITE, 8'h00, 32'h1234_5678);
		queue_word(npc_pkg::CMD_WRITE, 8'h01, 32'h1234_5678);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h01, 32'h1234_5678);
		queue_word(npc_pkg::CMD_WRITE, 8'h00, 32'hffff_ffff);
		queue_word(npc_pkg::CMD_LOOKUP, 8'hff, 32'hffff_ffff);
		// one channel at a time
		queue_word(npc_pkg::CMD_WRITE, 8'h80, 32'h0000_00ff);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h00, 32'h0000_00f0);
		queue_word(npc_pkg::CMD_WRITE, 8'h40, 32'hff00_0000);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h00, 32'hf000_0000);
		queue_word(npc_pkg::CMD_WRITE, 8'hc8, 32'h0000_ff00);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h00, 32'h0000_f000);
		queue_word(npc_pkg::CMD_WRITE, 8'h64, 32'h00ff_0000);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h00, 32'h00f0_0000);
		// equal distance to two different colours
		queue_word(npc_pkg::CMD_WRITE, 8'h02, 32'h0000_0010);
		queue_word(npc_pkg::CMD_WRITE, 8'h03, 32'h0000_0030);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h7e, 32'h0000_0020);
		queue_word(npc_pkg::CMD_LOOKUP, 8'h00, 32'h0000_0000);

		// load the whole palette, with lookups mixed in
		k = 0;
		for (int i = 0; i < npc_pkg::PALETTE_ENTRIES; i++) begin
			queue_word(npc_pkg::CMD_WRITE, npc_pkg::idx_t'(i), $urandom);
			k++;
			if ($urandom_range(0, 3) == 0) begin
				queue_word(npc_pkg::CMD_LOOKUP, rand_idx(),
					stim_palette[$urandom_range(0, i)]);
				k++;
			end
		end

		while (k < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				queue_word(npc_pkg::CMD_WRITE, rand_idx(), $urandom);
			end else if (r < 28) begin
				// copy of another entry, so lookups meet ties
				queue_word(npc_pkg::CMD_WRITE, rand_idx(),
					stim_palette[$urandom_range(0, npc_pkg::PALETTE_ENTRIES - 1)]);
			end else if (r < 60) begin
				queue_word(npc_pkg::CMD_LOOKUP, rand_idx(),
					stim_palette[$urandom_range(0, npc_pkg::PALETTE_ENTRIES - 1)]);
			end else if (r < 80) begin
				pix = nudge(stim_palette[$urandom_range(0, npc_pkg::PALETTE_ENTRIES - 1)]);
				queue_word(npc_pkg::CMD_LOOKUP, rand_idx(), pix);
			end else begin
				queue_word(npc_pkg::CMD_LOOKUP, rand_idx(), $urandom);
			end
			k++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_index.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_index.size() != 0)
			error_count += expected_index.size();
		$display("covered %0d palette writes and %0d lookups, %0d responses checked",
			writes_done, lookups_done, results_checked);
		$display("%0d cycles run, %0d errors", cycle_count, error_count);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
